@@ hdl/assert_macros.svh @@
// Assertion macros shared by the lock unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, checked out of reset.
`define ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent now, consequent on the next clock.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rwl_pkg.sv @@
// Types and constants shared by the reader-writer lock unit.
package rwl_pkg;

  typedef enum logic [1:0] {
    OP_RD_LOCK,
    OP_RD_UNLOCK,
    OP_WR_LOCK,
    OP_WR_UNLOCK
  } op_t;

  typedef enum logic [2:0] {
    ST_GRANTED,
    ST_QUEUED,
    ST_WAKE,
    ST_RELEASED,
    ST_FULL,
    ST_NOT_HELD
  } status_t;

  localparam logic [7:0] READER_MAX = 8'd255;

  // Drain count field; wide enough for the largest supported wait queue (127).
  localparam int QCNT_W = 7;

  // Command queue between front and back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW = 1;

  typedef struct packed {
    logic              drain;    // wake-all pass over count waiters
    status_t           status;
    logic [7:0]        id;
    logic [7:0]        readers;
    logic [QCNT_W-1:0] count;
  } cmd_t;

endpackage

@@ hdl/rwl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/rwl_cmd_fifo.sv @@
// Short command queue between the classify front and the result back end.
module rwl_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rwl_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output rwl_pkg::cmd_t  head_cmd,
  output logic           empty,
  output logic           full
);

  localparam int CW = $clog2(rwl_pkg::CMDQ_DEPTH + 1);

  rwl_pkg::cmd_t                  slots [rwl_pkg::CMDQ_DEPTH];
  logic [rwl_pkg::CMDQ_AW-1:0]    wr_ptr;
  logic [rwl_pkg::CMDQ_AW-1:0]    rd_ptr;
  logic [CW-1:0]                  cnt;

  assign head_cmd = slots[rd_ptr];
  assign empty    = (cnt == '0);
  assign full     = (cnt == CW'(rwl_pkg::CMDQ_DEPTH));

  function automatic logic [rwl_pkg::CMDQ_AW-1:0] ptr_inc(
    input logic [rwl_pkg::CMDQ_AW-1:0] p
  );
    return (p == rwl_pkg::CMDQ_AW'(rwl_pkg::CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr        <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

@@ hdl/rwl_front.sv @@
// Front end: accepts lock transactions, keeps lock state, queues refused ids.
module rwl_front #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS = 8,
  localparam int AW = $clog2(QUEUE_DEPTH),
  localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  input  logic [7:0]         requester_id,
  output logic               busy,
  input  logic               cmdq_full,
  input  logic               rd_issue,
  output logic               push,
  output rwl_pkg::cmd_t      push_cmd,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [ID_BITS-1:0] wr_data
);

  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_READING,
    MODE_WRITING
  } mode_t;

  mode_t         mode, mode_next;
  logic [7:0]    readers, readers_next;
  logic [FW-1:0] fill, fill_next;
  logic [AW-1:0] tail, tail_next;
  logic [FW-1:0] occ, occ_next;   // slots written and not yet read by the back end

  rwl_pkg::op_t         op;
  logic                 accept;
  logic                 q_full;
  logic                 do_refuse;
  logic                 do_release;
  logic [ID_BITS+7:0]   id_wide;
  logic [ID_BITS-1:0]   id_mask;
  logic [ID_BITS+7:0]   id_back;
  logic [7:0]           id8;

  assign op      = rwl_pkg::op_t'(operation);
  assign id_wide = {{ID_BITS{1'b0}}, requester_id};
  assign id_mask = id_wide[ID_BITS-1:0];
  assign id_back = {8'b0, id_mask};
  assign id8     = id_back[7:0];

  assign q_full = (fill == FW'(QUEUE_DEPTH));
  // Hold off while the command queue is full, or while every slot still waits to be drained by a pending wake pass.
  assign busy   = cmdq_full || ((occ == FW'(QUEUE_DEPTH)) && !q_full);
  assign accept = start && !busy;

  assign wr_addr = tail;
  assign wr_data = id_mask;

  always_comb begin
    mode_next    = mode;
    readers_next = readers;
    fill_next    = fill;
    tail_next    = tail;
    wr_en        = 1'b0;
    push         = 1'b0;
    do_refuse    = 1'b0;
    do_release   = 1'b0;
    push_cmd.drain   = 1'b0;
    push_cmd.status  = rwl_pkg::ST_GRANTED;
    push_cmd.id      = id8;
    push_cmd.readers = readers;
    push_cmd.count   = '0;

    if (accept) begin
      push = 1'b1;
      unique case (op)
        rwl_pkg::OP_RD_LOCK: begin
          if (mode != MODE_WRITING && readers != rwl_pkg::READER_MAX) begin
            readers_next = readers + 1'b1;
            mode_next    = MODE_READING;
          end else begin
            do_refuse = 1'b1;
          end
        end
        rwl_pkg::OP_RD_UNLOCK: begin
          if (mode != MODE_READING || readers == '0) begin
            push_cmd.status = rwl_pkg::ST_NOT_HELD;
          end else if (readers == 8'd1) begin
            do_release = 1'b1;
          end else begin
            readers_next    = readers - 1'b1;
            push_cmd.status = rwl_pkg::ST_RELEASED;
          end
        end
        rwl_pkg::OP_WR_LOCK: begin
          if (mode == MODE_FREE) begin
            mode_next = MODE_WRITING;
          end else begin
            do_refuse = 1'b1;
          end
        end
        rwl_pkg::OP_WR_UNLOCK: begin
          if (mode != MODE_WRITING) begin
            push_cmd.status = rwl_pkg::ST_NOT_HELD;
          end else begin
            do_release = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_refuse) begin
        if (q_full) begin
          push_cmd.status = rwl_pkg::ST_FULL;
        end else begin
          wr_en           = 1'b1;
          tail_next       = (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
          fill_next       = fill + 1'b1;
          push_cmd.status = rwl_pkg::ST_QUEUED;
        end
      end

      if (do_release) begin
        mode_next    = MODE_FREE;
        readers_next = '0;
        if (fill == '0) begin
          push_cmd.status = rwl_pkg::ST_RELEASED;
        end else begin
          push_cmd.drain  = 1'b1;
          push_cmd.status = rwl_pkg::ST_WAKE;
          push_cmd.count  = rwl_pkg::QCNT_W'(fill);
          fill_next       = '0;
        end
      end

      push_cmd.readers = readers_next;
    end
  end

  always_comb begin
    occ_next = occ;
    if (wr_en && !rd_issue) begin
      occ_next = occ + 1'b1;
    end else if (rd_issue && !wr_en) begin
      occ_next = occ - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_FREE;
      readers <= '0;
      fill    <= '0;
      tail    <= '0;
      occ     <= '0;
    end else begin
      mode    <= mode_next;
      readers <= readers_next;
      fill    <= fill_next;
      tail    <= tail_next;
      occ     <= occ_next;
    end
  end

endmodule

@@ hdl/rwl_back.sv @@
// Back end: turns queued commands into result strobes, draining waiters on release.
module rwl_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS = 8,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  rwl_pkg::cmd_t      head_cmd,
  input  logic               empty,
  output logic               pop,
  output logic               rd_en,
  output logic [AW-1:0]      rd_addr,
  input  logic [ID_BITS-1:0] rd_data,
  output logic               done,
  output logic [2:0]         status,
  output logic [7:0]         waiter_id,
  output logic               last,
  output logic [7:0]         reader_total
);

  logic [rwl_pkg::QCNT_W-1:0] rem;        // wake reads still to issue
  logic [AW-1:0]              head;
  logic                       pend;       // wake data arrives from the RAM this cycle
  logic                       pend_last;
  logic                       sv;         // single result held in s_* registers
  rwl_pkg::status_t           s_status;
  logic [7:0]                 s_id;
  logic [7:0]                 s_readers;
  logic [AW-1:0]              head_inc;
  logic [ID_BITS+7:0]         rd_wide;

  assign head_inc = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign pop      = (rem == '0) && !empty;
  assign rd_en    = (rem != '0) || (pop && head_cmd.drain);
  assign rd_addr  = head;
  assign rd_wide  = {8'b0, rd_data};

  assign done         = sv || pend;
  assign status       = pend ? rwl_pkg::ST_WAKE : s_status;
  assign waiter_id    = pend ? rd_wide[7:0] : s_id;
  assign last         = pend ? pend_last : 1'b1;
  assign reader_total = pend ? 8'd0 : s_readers;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= '0;
      head <= '0;
      pend <= 1'b0;
      sv   <= 1'b0;
    end else begin
      pend <= 1'b0;
      sv   <= 1'b0;
      if (rem != '0) begin
        head      <= head_inc;
        rem       <= rem - 1'b1;
        pend      <= 1'b1;
        pend_last <= (rem == rwl_pkg::QCNT_W'(1));
      end else if (!empty) begin
        if (head_cmd.drain) begin
          head      <= head_inc;
          rem       <= head_cmd.count - 1'b1;
          pend      <= 1'b1;
          pend_last <= (head_cmd.count == rwl_pkg::QCNT_W'(1));
        end else begin
          sv        <= 1'b1;
          s_status  <= head_cmd.status;
          s_id      <= head_cmd.id;
          s_readers <= head_cmd.readers;
        end
      end
    end
  end

endmodule

@@ hdl/reader_writer_lock_unit.sv @@
// Top level of the reader-writer lock unit with wake-all release.
// A result passes through the command queue, then the back end's result registers; it waits while a wake pass drains.
// Throughput: one transaction per cycle while busy is low; busy rises only when the 2-entry command queue fills
// or every wait-queue slot still awaits a wake pass. A release drains one waiter per cycle.
// Reset (rst, synchronous): lock free, no readers, wait queue empty; no result pending.
// The receiver cannot stall: each result is valid for exactly the cycle that done is high.
module reader_writer_lock_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation,
  input  logic [7:0] requester_id,
  output logic       done,
  output logic [2:0] status,
  output logic [7:0] waiter_id,
  output logic       last,
  output logic [7:0] reader_total
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  rwl_pkg::cmd_t      push_cmd;
  rwl_pkg::cmd_t      head_cmd;
  logic               push;
  logic               pop;
  logic               cmdq_empty;
  logic               cmdq_full;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ID_BITS-1:0] wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ID_BITS-1:0] rd_data;

  rwl_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS(ID_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .requester_id (requester_id),
    .busy         (busy),
    .cmdq_full    (cmdq_full),
    .rd_issue     (rd_en),
    .push         (push),
    .push_cmd     (push_cmd),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  rwl_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (cmdq_empty),
    .full     (cmdq_full)
  );

  rwl_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rwl_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS(ID_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_cmd     (head_cmd),
    .empty        (cmdq_empty),
    .pop          (pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .done         (done),
    .status       (status),
    .waiter_id    (waiter_id),
    .last         (last),
    .reader_total (reader_total)
  );

`include "assert_macros.svh"

  // A wake pass runs without gaps until its last waiter.
  `ASSERT_NEXT(a_drain_contiguous, done && !last, done && status == rwl_pkg::ST_WAKE, "wake gap")
  // Only wake results come in groups.
  `ASSERT_NOW(a_multi_is_wake, !(done && !last) || status == rwl_pkg::ST_WAKE, "non-wake result without last")
  // The lock is free once waiters are woken.
  `ASSERT_NOW(a_wake_no_readers, !(done && status == rwl_pkg::ST_WAKE) || reader_total == 8'd0, "wake with readers")

endmodule

@@ verif/tb_reader_writer_lock_unit.sv @@
// Self-checking testbench for the reader-writer lock unit with wake-all release.
`timescale 1ns / 100ps

module tb_reader_writer_lock_unit;

  typedef enum logic [1:0] {
    LK_FREE,
    LK_READING,
    LK_WRITING
  } lock_mode_t;

  // Tracks the lock state and holds the results each transaction should produce.
  class lock_scoreboard;
    localparam int WAIT_DEPTH = 16;
    localparam int MAX_PRINTED = 50;

    typedef struct packed {
      rwl_pkg::status_t status;
      logic [7:0]       waiter;
      logic             last;
      logic [7:0]       readers;
    } lock_result_t;

    lock_result_t expected_q[$];
    lock_mode_t   mode;
    logic [7:0]   readers;
    logic [7:0]   waiters[WAIT_DEPTH];
    int unsigned  head;
    int unsigned  tail;
    int unsigned  fill;
    int           errors;
    int           results_seen;
    int           wakes;
    int           full_refusals;
    int           saturated_refusals;

    function new();
      mode = LK_FREE;
      readers = '0;
      head = 0;
      tail = 0;
      fill = 0;
      errors = 0;
      results_seen = 0;
      wakes = 0;
      full_refusals = 0;
      saturated_refusals = 0;
    endfunction

    function void push_result(rwl_pkg::status_t st, logic [7:0] id, logic lst);
      lock_result_t r;
      r.status = st;
      r.waiter = id;
      r.last = lst;
      r.readers = readers;
      expected_q.push_back(r);
    endfunction

    function void refuse(logic [7:0] id);
      if (fill >= WAIT_DEPTH) begin
        full_refusals++;
        push_result(rwl_pkg::ST_FULL, id, 1'b1);
      end else begin
        waiters[tail] = id;
        tail = (tail + 1) % WAIT_DEPTH;
        fill++;
        push_result(rwl_pkg::ST_QUEUED, id, 1'b1);
      end
    endfunction

    // Lock goes free; every waiter is woken in arrival order.
    function void release_all(logic [7:0] id);
      logic [7:0] w;
      mode = LK_FREE;
      readers = '0;
      if (fill == 0) begin
        push_result(rwl_pkg::ST_RELEASED, id, 1'b1);
      end else begin
        while (fill > 0) begin
          w = waiters[head];
          head = (head + 1) % WAIT_DEPTH;
          fill--;
          wakes++;
          push_result(rwl_pkg::ST_WAKE, w, fill == 0);
        end
      end
    endfunction

    function void note_request(rwl_pkg::op_t op, logic [7:0] id);
      case (op)
        rwl_pkg::OP_RD_LOCK: begin
          if ((mode == LK_FREE || mode == LK_READING) && readers != rwl_pkg::READER_MAX) begin
            readers++;
            mode = LK_READING;
            push_result(rwl_pkg::ST_GRANTED, id, 1'b1);
          end else begin
            if (mode == LK_READING) saturated_refusals++;
            refuse(id);
          end
        end
        rwl_pkg::OP_RD_UNLOCK: begin
          if (mode != LK_READING || readers == 0) begin
            push_result(rwl_pkg::ST_NOT_HELD, id, 1'b1);
          end else begin
            readers--;
            if (readers == 0) release_all(id);
            else push_result(rwl_pkg::ST_RELEASED, id, 1'b1);
          end
        end
        rwl_pkg::OP_WR_LOCK: begin
          if (mode == LK_FREE) begin
            mode = LK_WRITING;
            push_result(rwl_pkg::ST_GRANTED, id, 1'b1);
          end else begin
            refuse(id);
          end
        end
        default: begin
          if (mode != LK_WRITING) push_result(rwl_pkg::ST_NOT_HELD, id, 1'b1);
          else release_all(id);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t ERROR %s", $time, msg);
    endtask

    task check_result(logic [2:0] st, logic [7:0] w, logic lst, logic [7:0] rd);
      lock_result_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: status %0d id %0d", st, w));
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", st, e.status));
      if (w !== e.waiter)
        report_mismatch($sformatf("waiter_id %0d, want %0d", w, e.waiter));
      if (lst !== e.last)
        report_mismatch($sformatf("last %0b, want %0b", lst, e.last));
      if (rd !== e.readers)
        report_mismatch($sformatf("reader_total %0d, want %0d", rd, e.readers));
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] operation;
  logic [7:0] requester_id;
  logic       done;
  logic [2:0] status;
  logic [7:0] waiter_id;
  logic       last;
  logic [7:0] reader_total;

  lock_scoreboard sb = new();
  int burst_left = 0;
  bit paced = 1'b0;
  int items_sent = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  reader_writer_lock_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .requester_id (requester_id),
    .done         (done),
    .status       (status),
    .waiter_id    (waiter_id),
    .last         (last),
    .reader_total (reader_total)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, waiter_id, last, reader_total);
  end

  function automatic logic [7:0] rand_id();
    return 8'($urandom);
  endfunction

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Bursts of random length with random gaps; now and then a long gapless stretch.
  task automatic pace();
    if (burst_left == 0) begin
      hold_off($urandom_range(0, 5));
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  task automatic send(rwl_pkg::op_t op, logic [7:0] id);
    if (paced) pace();
    @(negedge clk);
    start <= 1'b1;
    operation <= op;
    requester_id <= id;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(op, id);
    items_sent++;
  endtask

  task automatic free_lock();
    if (sb.mode == LK_WRITING) send(rwl_pkg::OP_WR_UNLOCK, rand_id());
    else if (sb.mode == LK_READING) repeat (sb.readers) send(rwl_pkg::OP_RD_UNLOCK, rand_id());
  endtask

  task automatic read_session();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send(rwl_pkg::OP_RD_LOCK, rand_id());
    repeat ($urandom_range(0, 4))
      send(($urandom_range(0, 3) == 0) ? rwl_pkg::OP_RD_LOCK : rwl_pkg::OP_WR_LOCK, rand_id());
    if ($urandom_range(0, 3) == 0) send(rwl_pkg::OP_WR_UNLOCK, rand_id());
    repeat (sb.readers) send(rwl_pkg::OP_RD_UNLOCK, rand_id());
  endtask

  // Writer holds the lock while others pile up, sometimes past the queue size.
  task automatic write_session();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
    send(rwl_pkg::OP_WR_LOCK, rand_id());
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) send(rwl_pkg::OP_RD_UNLOCK, rand_id());
      else send($urandom_range(0, 1) ? rwl_pkg::OP_RD_LOCK : rwl_pkg::OP_WR_LOCK, rand_id());
    end
    send(rwl_pkg::OP_WR_UNLOCK, rand_id());
  endtask

  initial begin
    int target;
    rst = 1'b1;
    start = 1'b0;
    operation = rwl_pkg::OP_RD_LOCK;
    requester_id = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: unlocks while free, shared read, refused writer, wake, write paths
    send(rwl_pkg::OP_RD_UNLOCK, 8'h00);
    send(rwl_pkg::OP_WR_UNLOCK, 8'hFF);
    send(rwl_pkg::OP_RD_LOCK, 8'h00);
    send(rwl_pkg::OP_RD_LOCK, 8'hFF);
    send(rwl_pkg::OP_WR_LOCK, 8'hA5);
    send(rwl_pkg::OP_WR_UNLOCK, 8'h5A);
    send(rwl_pkg::OP_RD_UNLOCK, 8'h00);
    send(rwl_pkg::OP_RD_UNLOCK, 8'hFF);
    send(rwl_pkg::OP_WR_LOCK, 8'h3C);
    send(rwl_pkg::OP_RD_LOCK, 8'hC3);
    send(rwl_pkg::OP_RD_UNLOCK, 8'h81);
    send(rwl_pkg::OP_WR_LOCK, 8'h7E);
    send(rwl_pkg::OP_WR_UNLOCK, 8'h3C);
    send(rwl_pkg::OP_WR_LOCK, 8'h01);
    send(rwl_pkg::OP_WR_UNLOCK, 8'h80);

    // overfill the wait queue, then wake all sixteen
    send(rwl_pkg::OP_WR_LOCK, rand_id());
    repeat (17)
      send($urandom_range(0, 1) ? rwl_pkg::OP_RD_LOCK : rwl_pkg::OP_WR_LOCK, rand_id());
    send(rwl_pkg::OP_WR_UNLOCK, rand_id());

    paced = 1'b1;
    target = 150;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) != 0) free_lock();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: write_session();
        4, 5, 6, 7: read_session();
        default: repeat ($urandom_range(1, 4))
          send(rwl_pkg::op_t'($urandom_range(0, 3)), rand_id());
      endcase
    end
    @(negedge clk);
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results, %0d waiters woken.",
             items_sent, sb.results_seen, sb.wakes);
    $display("Queue-full refusals: %0d; refusals at reader saturation: %0d.",
             sb.full_refusals, sb.saturated_refusals);
    if (sb.errors == 0) begin
      $display("PASS reader_writer_lock_unit");
    end else begin
      $display("FAIL reader_writer_lock_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still pending.", sb.expected_q.size());
    $display("FAIL reader_writer_lock_unit");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rwl_pkg.sv
hdl/rwl_ram.sv
hdl/rwl_cmd_fifo.sv
hdl/rwl_front.sv
hdl/rwl_back.sv
hdl/reader_writer_lock_unit.sv
verif/tb_reader_writer_lock_unit.sv
